### hdl/blr_pkg.sv
// ----------------------------------------------------------------------------
// Bresenham line rasteriser package
// Widths, codes and item layouts shared by the line rasteriser.
// ----------------------------------------------------------------------------
package blr_pkg;

  localparam int COORD_BITS = 13;
  localparam int DELTA_BITS = COORD_BITS + 1;
  localparam int CNT_BITS   = COORD_BITS + 1;
  localparam int ERR_BITS   = COORD_BITS + 3;
  localparam int COLOR_BITS = 24;
  localparam int DIM_BITS   = 13;
  localparam int CMP_BITS   = (COORD_BITS > DIM_BITS) ? COORD_BITS : DIM_BITS;
  localparam int ADDR_BITS  = 3;
  localparam int DATA_BITS  = 32;

  localparam int CMD_BITS      = 4 * COORD_BITS + COLOR_BITS;
  localparam int IN_TDATA_BITS = ((CMD_BITS + 7) / 8) * 8;
  localparam int PIX_BITS      = 2 * COORD_BITS + COLOR_BITS + 1;
  localparam int OUT_TDATA_BITS = ((PIX_BITS + 7) / 8) * 8;

  localparam logic [DIM_BITS-1:0] WIDTH_RESET  = DIM_BITS'(640);
  localparam logic [DIM_BITS-1:0] HEIGHT_RESET = DIM_BITS'(480);

  typedef enum logic {
    OP_LINE = 1'b0,
    OP_STEP = 1'b1
  } op_t;

  typedef enum logic {
    REG_SURFACE_WIDTH  = 1'b0,
    REG_SURFACE_HEIGHT = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic y_neg;
    logic x_neg;
    logic x_major;
  } step_dirs_t;

  typedef struct packed {
    logic [COLOR_BITS-1:0] line_color;
    logic [COORD_BITS-1:0] y_end;
    logic [COORD_BITS-1:0] x_end;
    logic [COORD_BITS-1:0] y_start;
    logic [COORD_BITS-1:0] x_start;
  } line_cmd_t;

  typedef struct packed {
    logic                  write_enable;
    logic [COLOR_BITS-1:0] pixel_color;
    logic [COORD_BITS-1:0] pixel_y;
    logic [COORD_BITS-1:0] pixel_x;
  } pixel_t;

endpackage

### hdl/bresenham_line_rasterizer.sv
// ----------------------------------------------------------------------------
// Bresenham line rasteriser
// Sets up a line from a command item and emits one pixel per step item while a line is active.
// ----------------------------------------------------------------------------
// The block takes one item in every clock cycle. A line command is set up in
// the cycle it is accepted, and each step item emits one pixel into the
// output register, one error add and compare on the registered stepper state.
// The input side stalls only while a pixel waits in the output register
// untaken.
module bresenham_line_rasterizer (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // x_start, y_start, x_end, y_end, line_color, zero padding
  input  logic [blr_pkg::IN_TDATA_BITS-1:0]    s_tdata,
  // op
  input  logic [0:0]                           s_tuser,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // pixel_x, pixel_y, pixel_color, write_enable, zero padding
  output logic [blr_pkg::OUT_TDATA_BITS-1:0]   m_tdata,
  output logic                                 m_tlast,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [blr_pkg::ADDR_BITS-1:0]        paddr,
  input  logic [blr_pkg::DATA_BITS-1:0]        pwdata,
  output logic [blr_pkg::DATA_BITS-1:0]        prdata,
  output logic                                 pready
);

  localparam int CB = blr_pkg::COORD_BITS;
  localparam int DB = blr_pkg::DELTA_BITS;
  localparam int NB = blr_pkg::CNT_BITS;
  localparam int EB = blr_pkg::ERR_BITS;

  logic [blr_pkg::DIM_BITS-1:0]   surface_width, surface_height;
  logic                           active, active_next;
  logic [CB-1:0]                  cur_x, cur_x_next, cur_y, cur_y_next;
  logic [EB-1:0]                  error_term, error_term_next;
  logic [EB-1:0]                  inc_straight, inc_straight_next;
  logic [EB-1:0]                  inc_diagonal, inc_diagonal_next;
  blr_pkg::step_dirs_t            step_dirs, step_dirs_next;
  logic [NB-1:0]                  pixels_left, pixels_left_next;
  logic [blr_pkg::COLOR_BITS-1:0] held_color, held_color_next;
  blr_pkg::pixel_t                out_pixel, out_pixel_next;
  logic                           out_last, out_last_next;
  logic                           out_valid, out_valid_next;

  blr_pkg::line_cmd_t             cmd;
  logic                           in_accept, is_step, cfg_write;
  logic signed [DB-1:0]           dx_raw, dy_raw;
  logic [DB-1:0]                  dx_abs, dy_abs, d_maj, d_min;
  logic [EB-1:0]                  min2, maj2;
  blr_pkg::step_dirs_t            dirs_new;
  logic                           take_diag, is_last, in_bounds;

  assign cmd       = blr_pkg::line_cmd_t'(s_tdata[blr_pkg::CMD_BITS-1:0]);
  assign is_step   = (blr_pkg::op_t'(s_tuser[0]) == blr_pkg::OP_STEP);
  assign s_tready  = !out_valid || m_tready;
  assign in_accept = s_tvalid && s_tready;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    case (blr_pkg::reg_index_t'(paddr[2]))
      blr_pkg::REG_SURFACE_WIDTH:  prdata = blr_pkg::DATA_BITS'(surface_width);
      blr_pkg::REG_SURFACE_HEIGHT: prdata = blr_pkg::DATA_BITS'(surface_height);
      default:                     prdata = '0;
    endcase
  end

  // Line setup.
  always_comb begin
    dx_raw = $signed({cmd.x_end[CB-1], cmd.x_end}) - $signed({cmd.x_start[CB-1], cmd.x_start});
    dy_raw = $signed({cmd.y_end[CB-1], cmd.y_end}) - $signed({cmd.y_start[CB-1], cmd.y_start});
    dx_abs = dx_raw[DB-1] ? DB'(-dx_raw) : DB'(dx_raw);
    dy_abs = dy_raw[DB-1] ? DB'(-dy_raw) : DB'(dy_raw);
    dirs_new.x_major = (dx_abs >= dy_abs);
    dirs_new.x_neg   = ($signed(cmd.x_start) > $signed(cmd.x_end));
    dirs_new.y_neg   = ($signed(cmd.y_start) > $signed(cmd.y_end));
    d_maj = dirs_new.x_major ? dx_abs : dy_abs;
    d_min = dirs_new.x_major ? dy_abs : dx_abs;
    min2  = EB'({d_min, 1'b0});
    maj2  = EB'({d_maj, 1'b0});
  end

  // Pixel step.
  always_comb begin
    take_diag = !error_term[EB-1];
    is_last   = (pixels_left <= NB'(1));
    in_bounds = !cur_x[CB-1] && !cur_y[CB-1] &&
                (blr_pkg::CMP_BITS'(cur_x) < blr_pkg::CMP_BITS'(surface_width)) &&
                (blr_pkg::CMP_BITS'(cur_y) < blr_pkg::CMP_BITS'(surface_height));
  end

  always_comb begin
    active_next       = active;
    cur_x_next        = cur_x;
    cur_y_next        = cur_y;
    error_term_next   = error_term;
    inc_straight_next = inc_straight;
    inc_diagonal_next = inc_diagonal;
    step_dirs_next    = step_dirs;
    pixels_left_next  = pixels_left;
    held_color_next   = held_color;
    out_pixel_next    = out_pixel;
    out_last_next     = out_last;
    out_valid_next    = out_valid && !m_tready;
    if (in_accept && !is_step) begin
      active_next       = 1'b1;
      cur_x_next        = cmd.x_start;
      cur_y_next        = cmd.y_start;
      error_term_next   = min2 - EB'(d_maj);
      inc_straight_next = min2;
      inc_diagonal_next = min2 - maj2;
      step_dirs_next    = dirs_new;
      pixels_left_next  = NB'(d_maj) + NB'(1);
      held_color_next   = cmd.line_color;
    end else if (in_accept && active) begin
      out_valid_next              = 1'b1;
      out_pixel_next.pixel_x      = cur_x;
      out_pixel_next.pixel_y      = cur_y;
      out_pixel_next.pixel_color  = held_color;
      out_pixel_next.write_enable = in_bounds;
      out_last_next               = is_last;
      error_term_next = error_term + (take_diag ? inc_diagonal : inc_straight);
      if (take_diag || step_dirs.x_major) begin
        cur_x_next = cur_x + {{(CB-1){step_dirs.x_neg}}, 1'b1};
      end
      if (take_diag || !step_dirs.x_major) begin
        cur_y_next = cur_y + {{(CB-1){step_dirs.y_neg}}, 1'b1};
      end
      if (is_last) begin
        active_next      = 1'b0;
        pixels_left_next = '0;
      end else begin
        pixels_left_next = pixels_left - NB'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      surface_width  <= blr_pkg::WIDTH_RESET;
      surface_height <= blr_pkg::HEIGHT_RESET;
    end else if (cfg_write) begin
      case (blr_pkg::reg_index_t'(paddr[2]))
        blr_pkg::REG_SURFACE_WIDTH:  surface_width  <= pwdata[blr_pkg::DIM_BITS-1:0];
        blr_pkg::REG_SURFACE_HEIGHT: surface_height <= pwdata[blr_pkg::DIM_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active       <= 1'b0;
      cur_x        <= '0;
      cur_y        <= '0;
      error_term   <= '0;
      inc_straight <= '0;
      inc_diagonal <= '0;
      step_dirs    <= '0;
      pixels_left  <= '0;
      held_color   <= '0;
      out_valid    <= 1'b0;
    end else begin
      active       <= active_next;
      cur_x        <= cur_x_next;
      cur_y        <= cur_y_next;
      error_term   <= error_term_next;
      inc_straight <= inc_straight_next;
      inc_diagonal <= inc_diagonal_next;
      step_dirs    <= step_dirs_next;
      pixels_left  <= pixels_left_next;
      held_color   <= held_color_next;
      out_valid    <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    out_pixel <= out_pixel_next;
    out_last  <= out_last_next;
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = blr_pkg::OUT_TDATA_BITS'(out_pixel);
  assign m_tlast  = out_last;

  a_active_has_pixels: assert property (@(posedge clk) disable iff (rst)
    active |-> (pixels_left != '0))
    else $error("line active with no pixels left");

  a_idle_step_silent: assert property (@(posedge clk) disable iff (rst)
    (in_accept && is_step && !active) |=> !m_tvalid)
    else $error("step while idle produced a pixel");

  a_command_loads: assert property (@(posedge clk) disable iff (rst)
    (in_accept && !is_step) |=> (active && !m_tvalid))
    else $error("line command did not start a line cleanly");

endmodule
